FILE: src/lttc_pkg.sv
// Shared constants and the cosine table generator for the lidar TTC brake core.
// No dependencies; used by lidar_time_to_collision_brake_core.
package lttc_pkg;

  // Fixed-point constants (Q30)
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [15:0] TTC_NONE   = 16'hFFFF;
  localparam logic [9:0]  DIST_SCALE = 10'd1000;

  // Input action codes
  localparam logic ACTION_SPEED  = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TTC_THRESH  = 8'd4;

  // Register reset values
  localparam logic [15:0] RST_RANGE_MIN   = 16'd60;
  localparam logic [15:0] RST_RANGE_MAX   = 16'd30000;
  localparam logic [15:0] RST_START_ANGLE = 16'hA000;
  localparam logic [15:0] RST_ANGLE_STEP  = 16'd46;
  localparam logic [15:0] RST_TTC_THRESH  = 16'd1000;

  // Q15 cosine of a Q30 angle x in [0, pi/2), Horner series, elaboration only
  function automatic logic [15:0] cos_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sub;
    x2  = (x * x) >> 30;
    t   = Q30_ONE;
    sub = ((x2 * t) >> 30) / 64'd132;
    t   = (sub >= Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
    sub = ((x2 * t) >> 30) / 64'd90;
    t   = (sub >= Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
    sub = ((x2 * t) >> 30) / 64'd56;
    t   = (sub >= Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
    sub = ((x2 * t) >> 30) / 64'd30;
    t   = (sub >= Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
    sub = ((x2 * t) >> 30) / 64'd12;
    t   = (sub >= Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
    sub = ((x2 * t) >> 30) / 64'd2;
    t   = (sub >= Q30_ONE) ? 64'd0 : (Q30_ONE - sub);
    return 16'((t + 64'd16384) >> 15);
  endfunction

endpackage

FILE: src/lidar_time_to_collision_brake_core.sv
// Lidar time-to-collision emergency brake core: top level.
// Depends on lttc_pkg (constants, cosine table generator).
//
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tdata: speed_mm_s[15:0], distance_mm[31:16]
//         |     |                      | tuser: action[0], sample_valid[1]; tlast: last_sample
// out_    | out | out_tvalid/out_tready| tdata: brake[0], min_ttc_ms[16:1]
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// Speed update: taken in the idle state. Beam: cosine ROM read, one multiply, a prepare
// step and, if a division runs, a restoring divider making 16 quotient bits, one per cycle.
// Reset is synchronous; the cosine ROM is constant and needs no clearing pass.
// A result waits in the output register; the next scan's last beam holds in its final
// state until that register is free.
module lidar_time_to_collision_brake_core #(
  parameter int unsigned COS_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // speed_mm_s[15:0], distance_mm[31:16]
  input  logic [1:0]  in_tuser,   // action[0], sample_valid[1]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // brake[0], min_ttc_ms[16:1], zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lttc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned AW = (COS_TABLE_DEPTH > 1) ? $clog2(COS_TABLE_DEPTH) : 1;
  localparam int unsigned PW = 15 + $clog2(COS_TABLE_DEPTH + 1);
  localparam int unsigned KW = PW - 14;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROM, ST_MUL, ST_PREP, ST_DIV, ST_DONE
  } state_t;

  state_t state_r;

  // config
  logic [15:0] range_min_r, range_max_r, start_angle_r, angle_step_r, ttc_thresh_r;

  // scan state
  logic signed [15:0] speed_r;
  logic [15:0] beam_angle_r;
  logic        scan_start_r;
  logic [15:0] min_ttc_r;

  // beam pipeline
  logic [AW-1:0]      rom_addr_r;
  logic               neg_r, zero_r;
  logic [15:0]        rom_q_r;
  logic signed [32:0] closing_r;
  logic [25:0]        dist_k_r;
  logic               use_r, last_r, ttc_ok_r;
  logic [30:0]        rem_r, div_r;
  logic [15:0]        num_lo_r, quo_r;
  logic [3:0]         cnt_r;

  // result
  logic        out_valid_r, out_brake_r;
  logic [15:0] out_min_r;

  // cosine ROM
  logic [15:0] cos_rom [COS_TABLE_DEPTH];
  for (genvar gk = 0; gk < COS_TABLE_DEPTH; gk++) begin : g_rom
    localparam logic [63:0] XK =
      (lttc_pkg::HALF_PI_Q30 * 64'(gk)) / 64'(COS_TABLE_DEPTH);
    assign cos_rom[gk] = lttc_pkg::cos_entry(XK);
  end

  always_ff @(posedge clk) begin
    rom_q_r <= cos_rom[rom_addr_r];
  end

  // angle and table address
  logic [15:0]   cur_angle_w, beam_angle_nxt;
  logic [1:0]    quad_w;
  logic [13:0]   phase_w;
  logic [14:0]   u_w;
  logic [PW-1:0] kprod_w;
  logic [KW-1:0] kfull_w;
  logic [AW-1:0] addr_w;
  logic          neg_w;

  assign cur_angle_w    = scan_start_r ? start_angle_r : beam_angle_r;
  assign beam_angle_nxt = cur_angle_w + angle_step_r;
  assign quad_w         = cur_angle_w[15:14];
  assign phase_w        = cur_angle_w[13:0];
  assign u_w            = quad_w[0] ? (15'd16384 - {1'b0, phase_w}) : {1'b0, phase_w};
  assign neg_w          = (quad_w == 2'd1) || (quad_w == 2'd2);
  assign kprod_w        = PW'(u_w) * PW'(COS_TABLE_DEPTH);
  assign kfull_w        = kprod_w[PW-1:14];
  assign addr_w         = (kfull_w >= KW'(COS_TABLE_DEPTH)) ? AW'(COS_TABLE_DEPTH - 1)
                                                            : kfull_w[AW-1:0];

  // input decode
  logic [15:0] in_speed_w, in_dist_w;
  logic        in_action_w, in_valid_w, accept_w;
  assign in_speed_w  = in_tdata[15:0];
  assign in_dist_w   = in_tdata[31:16];
  assign in_action_w = in_tuser[0];
  assign in_valid_w  = in_tuser[1];
  assign in_tready   = (state_r == ST_IDLE);
  assign accept_w    = in_tvalid && in_tready;

  // multiply and divide helpers
  logic signed [16:0] rom_s_w, cos_w;
  logic signed [32:0] spd_ext_w, cos_ext_w;
  logic        closing_pos_w;
  logic [31:0] trial_w;
  logic        trial_ge_w;
  logic [15:0] min_new_w;
  logic        out_free_w, emit_w;

  assign rom_s_w       = $signed({1'b0, rom_q_r});
  assign cos_w         = zero_r ? 17'sd0 : (neg_r ? -rom_s_w : rom_s_w);
  assign spd_ext_w     = 33'(speed_r);
  assign cos_ext_w     = 33'(cos_w);
  assign closing_pos_w = !closing_r[32] && (closing_r != 33'sd0);
  assign trial_w       = {rem_r, num_lo_r[15]};
  assign trial_ge_w    = trial_w >= {1'b0, div_r};
  assign min_new_w     = (ttc_ok_r && (quo_r < min_ttc_r)) ? quo_r : min_ttc_r;
  assign out_free_w    = !out_valid_r || out_tready;
  assign emit_w        = (state_r == ST_DONE) && last_r && out_free_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      range_min_r   <= lttc_pkg::RST_RANGE_MIN;
      range_max_r   <= lttc_pkg::RST_RANGE_MAX;
      start_angle_r <= lttc_pkg::RST_START_ANGLE;
      angle_step_r  <= lttc_pkg::RST_ANGLE_STEP;
      ttc_thresh_r  <= lttc_pkg::RST_TTC_THRESH;
      speed_r       <= 16'sd0;
      beam_angle_r  <= 16'd0;
      scan_start_r  <= 1'b1;
      min_ttc_r     <= lttc_pkg::TTC_NONE;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          lttc_pkg::REG_RANGE_MIN:   range_min_r   <= cfg_data;
          lttc_pkg::REG_RANGE_MAX:   range_max_r   <= cfg_data;
          lttc_pkg::REG_START_ANGLE: start_angle_r <= cfg_data;
          lttc_pkg::REG_ANGLE_STEP:  angle_step_r  <= cfg_data;
          lttc_pkg::REG_TTC_THRESH:  ttc_thresh_r  <= cfg_data;
          default: ;
        endcase
      end

      if (emit_w) begin
        out_valid_r <= 1'b1;
        out_min_r   <= min_new_w;
        out_brake_r <= min_new_w < ttc_thresh_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept_w) begin
            if (in_action_w == lttc_pkg::ACTION_SPEED) begin
              speed_r <= $signed(in_speed_w);
            end else begin
              beam_angle_r <= beam_angle_nxt;
              scan_start_r <= 1'b0;
              rom_addr_r   <= addr_w;
              neg_r        <= neg_w;
              zero_r       <= u_w[14];
              dist_k_r     <= 26'(in_dist_w) * 26'(lttc_pkg::DIST_SCALE);
              use_r        <= in_valid_w && (in_dist_w >= range_min_r) &&
                              (in_dist_w <= range_max_r);
              last_r       <= in_tlast;
              state_r      <= ST_ROM;
            end
          end
        end
        ST_ROM: state_r <= ST_MUL;
        ST_MUL: begin
          closing_r <= spd_ext_w * cos_ext_w;
          state_r   <= ST_PREP;
        end
        ST_PREP: begin
          ttc_ok_r <= 1'b0;
          state_r  <= ST_DONE;
          // quotient >= 65536 saturates and can never lower the minimum
          if (use_r && closing_pos_w &&
              (31'(dist_k_r[25:1]) < closing_r[30:0])) begin
            rem_r    <= 31'(dist_k_r[25:1]);
            div_r    <= closing_r[30:0];
            num_lo_r <= {dist_k_r[0], 15'd0};
            cnt_r    <= 4'd0;
            ttc_ok_r <= 1'b1;
            state_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r    <= trial_ge_w ? 31'(trial_w - {1'b0, div_r}) : trial_w[30:0];
          quo_r    <= {quo_r[14:0], trial_ge_w};
          num_lo_r <= {num_lo_r[14:0], 1'b0};
          cnt_r    <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!last_r) begin
            min_ttc_r <= min_new_w;
            state_r   <= ST_IDLE;
          end else if (out_free_w) begin
            min_ttc_r    <= lttc_pkg::TTC_NONE;
            scan_start_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_min_r, out_brake_r};
  assign cfg_ready  = 1'b1;

  a_div_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_r != 31'd0))
    else $error("division by zero closing speed");

  a_emit_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    emit_w |=> (scan_start_r && (min_ttc_r == lttc_pkg::TTC_NONE)))
    else $error("scan not rearmed after result");

  a_brake_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_brake_r == (out_min_r < ttc_thresh_r)))
    else $error("brake flag inconsistent with minimum ttc");

endmodule

FILE: tb/sv/lidar_time_to_collision_brake_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lidar_time_to_collision_brake_core: directed table, then random scans
// checked against a cycle-free TTC predictor. Depends on lttc_pkg and the core RTL only.
module lidar_time_to_collision_brake_core_tb;

  localparam int unsigned COS_DEPTH     = 1024;
  localparam logic [63:0] Q30_UNIT      = 64'd1073741824;
  localparam logic [63:0] HALF_PI_FX    = 64'd1686629713;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          STALL_LIMIT   = 4000;
  localparam int          HOLD_CYCLES   = 600;
  localparam int          PHASES        = 6;
  localparam int          PHASE_ITEMS   = 122;
  localparam int unsigned IDX_W         = lttc_pkg::CFG_IDX_W;
  localparam logic [IDX_W-1:0] REG_UNUSED = 8'hFF;
  localparam logic [IDX_W-1:0] R_MIN      = lttc_pkg::REG_RANGE_MIN;
  localparam logic [IDX_W-1:0] R_MAX      = lttc_pkg::REG_RANGE_MAX;
  localparam logic [IDX_W-1:0] R_START    = lttc_pkg::REG_START_ANGLE;
  localparam logic [IDX_W-1:0] R_STEP     = lttc_pkg::REG_ANGLE_STEP;
  localparam logic [IDX_W-1:0] R_THR      = lttc_pkg::REG_TTC_THRESH;
  localparam logic             A_SPD      = lttc_pkg::ACTION_SPEED;
  localparam logic             A_BEAM     = lttc_pkg::ACTION_SAMPLE;

  typedef struct packed {
    logic              action;
    logic signed [15:0] speed;
    logic [15:0]       range_mm;
    logic              valid;
    logic              last;
  } sample_t;

  typedef struct packed {
    logic        brake;
    logic [15:0] ttc;
  } ttc_result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [IDX_W-1:0]      idx;
    logic                  action;
    logic [15:0]           word;
    logic [15:0]           range_mm;
    logic                  valid;
    logic                  last;
    logic                  typed;
    logic                  exp_brake;
    logic [15:0]           exp_ttc;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // speed_mm_s[15:0], distance_mm[31:16]
  logic [1:0]  in_tuser;   // action[0], sample_valid[1]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // brake[0], min_ttc_ms[16:1], zero fill
  logic        cfg_valid;
  logic        cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  lidar_time_to_collision_brake_core #(
    .COS_TABLE_DEPTH(COS_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state and register copies
  logic [15:0]        cos_rom [COS_DEPTH];
  logic signed [15:0] fwd_speed;
  logic [15:0]        next_angle;
  bit                 scan_armed;
  int                 scan_min;
  logic [15:0]        lim_min, lim_max, first_angle, angle_inc, brake_thresh;

  ttc_result_t ttc_due [$];
  ttc_result_t due;
  int          mismatch_count;
  int          src_idle_pct;
  int          rcv_idle_pct;
  int          hold_left;
  bit          hold_req;
  bit          items_since_settle;
  int          stall_run;

  dir_row_t dir_rows [26] = '{
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'd1000,  1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFF},
    '{ROW_ITEM, R_MIN,   A_SPD,  16'h7FFF,  16'hFFFF,  1'b1, 1'b1, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  R_MIN,   A_BEAM, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  R_MAX,   A_BEAM, 16'hFFFF,  16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  R_START, A_BEAM, 16'h0000,  16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  R_STEP,  A_BEAM, 16'h4000,  16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  R_THR,   A_BEAM, 16'hFFFF,  16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    // one beam per quadrant; zero distance dead ahead gives zero TTC
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'd0,     1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'd20,    1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'd20,    1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'd20,    1'b1, 1'b1, 1'b1, 1'b1, 16'd0},
    // full reverse speed: only the rear beam closes
    '{ROW_ITEM, R_MIN,   A_SPD,  16'h8000,  16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'hFFFF,  1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'hFFFF,  1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'hFFFF,  1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'd300,   1'b1, 1'b1, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'd500,   1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF},
    // inverted limits, plus a write to a register that does not exist
    '{ROW_CFG,  R_MIN,   A_BEAM, 16'd5000,  16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  R_MAX,   A_BEAM, 16'd100,   16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  REG_UNUSED, A_BEAM, 16'h0000, 16'd0,   1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'd2000,  1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFF},
    '{ROW_CFG,  R_MIN,   A_BEAM, 16'd60,    16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  R_MAX,   A_BEAM, 16'd30000, 16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_CFG,  R_THR,   A_BEAM, 16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    // crawling speed: TTC saturates
    '{ROW_ITEM, R_MIN,   A_SPD,  16'd1,     16'd0,     1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM, R_MIN,   A_BEAM, 16'd0,     16'd30000, 1'b1, 1'b1, 1'b1, 1'b0, 16'hFFFF}
  };

  // Q15 cosine of table entry k, Q30 series evaluated innermost term first
  function automatic logic [15:0] cos_table_entry(input int unsigned k);
    logic [63:0] ang;
    logic [63:0] sq;
    logic [63:0] acc;
    logic [63:0] term;
    ang = HALF_PI_FX * 64'(k) / 64'(COS_DEPTH);
    sq  = (ang * ang) >> 30;
    acc = Q30_UNIT;
    for (int j = 6; j >= 1; j--) begin
      term = ((sq * acc) >> 30) / 64'((2 * j) * (2 * j - 1));
      acc  = (term >= Q30_UNIT) ? 64'd0 : (Q30_UNIT - term);
    end
    return 16'((acc + 64'd16384) >> 15);
  endfunction

  function automatic int rom_lookup(input int unsigned u);
    int unsigned k;
    if (u >= 16384) return 0;
    k = (u * COS_DEPTH) >> 14;
    if (k >= COS_DEPTH) k = COS_DEPTH - 1;
    return int'(cos_rom[k]);
  endfunction

  function automatic int beam_cos(input logic [15:0] ang);
    int unsigned p;
    p = int'(ang[13:0]);
    case (ang[15:14])
      2'd0: return rom_lookup(p);
      2'd1: return -rom_lookup(16384 - p);
      2'd2: return -rom_lookup(p);
      default: return rom_lookup(16384 - p);
    endcase
  endfunction

  function automatic void predictor_reset();
    lim_min      = lttc_pkg::RST_RANGE_MIN;
    lim_max      = lttc_pkg::RST_RANGE_MAX;
    first_angle  = lttc_pkg::RST_START_ANGLE;
    angle_inc    = lttc_pkg::RST_ANGLE_STEP;
    brake_thresh = lttc_pkg::RST_TTC_THRESH;
    fwd_speed    = '0;
    next_angle   = '0;
    scan_armed   = 1'b1;
    scan_min     = 65535;
  endfunction

  function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
    case (idx)
      R_MIN:   lim_min = val;
      R_MAX:   lim_max = val;
      R_START: first_angle = val;
      R_STEP:  angle_inc = val;
      R_THR:   brake_thresh = val;
      default: ;
    endcase
  endfunction

  function automatic void predict_ttc_step(input sample_t s, output bit emits,
                                           output ttc_result_t res);
    logic [15:0] ang;
    longint      closing;
    longint      quot;
    emits = 1'b0;
    res   = '0;
    if (s.action == A_SPD) begin
      fwd_speed = s.speed;
      return;
    end
    if (scan_armed) begin
      next_angle = first_angle;
      scan_armed = 1'b0;
    end
    ang        = next_angle;
    next_angle = next_angle + angle_inc;
    if (s.valid && s.range_mm >= lim_min && s.range_mm <= lim_max) begin
      closing = longint'(fwd_speed) * longint'(beam_cos(ang));
      if (closing > 0) begin
        quot = (longint'(s.range_mm) * 64'sd32768000) / closing;
        if (quot > 65535) quot = 65535;
        if (quot < scan_min) scan_min = int'(quot);
      end
    end
    if (s.last) begin
      emits      = 1'b1;
      res.brake  = (scan_min < int'(brake_thresh));
      res.ttc    = 16'(scan_min);
      scan_min   = 65535;
      scan_armed = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic send_item(input sample_t s, input bit typed, input ttc_result_t typed_res);
    bit          emits;
    ttc_result_t res;
    if (cfg_valid) cfg_valid <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {s.range_mm, s.speed};
    in_tuser  <= {s.valid, s.action};
    in_tlast  <= s.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_ttc_step(s, emits, res);
    if (emits) ttc_due.push_back(typed ? typed_res : res);
    items_since_settle = 1'b1;
  endtask

  // drain results, then cover a beam that may still be dividing
  task automatic settle();
    in_tvalid <= 1'b0;
    while (ttc_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    items_since_settle = 1'b0;
  endtask

  task automatic set_phase_regs(input int phase);
    logic [15:0] v [5];
    case (phase)
      0: v = '{16'd60, 16'd30000, 16'hA000, 16'd46, 16'd1000};
      1: v = '{16'd0, 16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF};
      2: v = '{16'd200, 16'd20000, 16'h7FFF, 16'd0, 16'd0};
      default: v = '{16'($urandom_range(0, 3000)), 16'($urandom_range(8000, 65535)),
                     16'($urandom), 16'($urandom_range(0, 2047)), 16'($urandom_range(0, 65535))};
    endcase
    write_reg(R_MIN, v[0]);
    write_reg(R_MAX, v[1]);
    write_reg(R_START, v[2]);
    write_reg(R_STEP, v[3]);
    write_reg(R_THR, v[4]);
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    s.action   = ($urandom_range(99) < 8) ? A_SPD : A_BEAM;
    s.speed    = ($urandom_range(99) < 75) ? 16'($urandom_range(300, 32767)) : 16'($urandom);
    s.range_mm = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 40000)) : 16'($urandom);
    s.valid    = ($urandom_range(99) < 90);
    s.last     = ($urandom_range(99) < 10);
    return s;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int k = 0; k < COS_DEPTH; k++) cos_rom[k] = cos_table_entry(k);
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (ttc_due.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", out_tdata));
      end else begin
        due = ttc_due.pop_front();
        if (out_tdata[0] !== due.brake)
          report_mismatch($sformatf("brake %b, want %b", out_tdata[0], due.brake));
        if (out_tdata[16:1] !== due.ttc)
          report_mismatch($sformatf("min_ttc_ms %0d, want %0d", out_tdata[16:1], due.ttc));
      end
    end
  end

  initial begin
    stall_run = 0;
    while (stall_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_run = 0;
      else
        stall_run++;
    end
    $display("lidar_time_to_collision_brake_core test failed");
    $finish;
  end

  initial begin
    sample_t     s;
    ttc_result_t tres;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    in_tlast   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    mismatch_count     = 0;
    hold_left          = 0;
    hold_req           = 1'b0;
    items_since_settle = 1'b0;
    src_idle_pct       = 34;
    rcv_idle_pct       = 84;
    predictor_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (items_since_settle) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].word);
      end else begin
        s.action   = dir_rows[i].action;
        s.speed    = dir_rows[i].word;
        s.range_mm = dir_rows[i].range_mm;
        s.valid    = dir_rows[i].valid;
        s.last     = dir_rows[i].last;
        tres.brake = dir_rows[i].exp_brake;
        tres.ttc   = dir_rows[i].exp_ttc;
        send_item(s, dir_rows[i].typed, tres);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase / 2)
        0: begin
          src_idle_pct = 34;
          rcv_idle_pct = 84;
        end
        1: begin
          src_idle_pct = 84;
          rcv_idle_pct = 34;
        end
        default: begin
          src_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      set_phase_regs(phase);
      // long receiver stall with the sender still pushing requests
      if (phase == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_sample(), 1'b0, '0);
    end

    settle();
    if (mismatch_count == 0)
      $display("lidar_time_to_collision_brake_core test passed");
    else
      $display("lidar_time_to_collision_brake_core test failed");
    $finish;
  end

endmodule
